### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file. Each macro expects the
// signals clk and rst to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ladsr_pkg.sv
// ----------------------------------------------------------------------------
// ladsr_pkg
// Shared widths, stage codes, register indexes and helpers for the linear
// ADSR envelope block.
// ----------------------------------------------------------------------------
package ladsr_pkg;

  // level and register widths
  localparam int LEVEL_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int STAGE_W   = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = {LEVEL_W{1'b1}};
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = '0;

  // envelope stage codes as seen on stage_code
  typedef enum logic [STAGE_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4,
    ST_FADE    = 3'd5
  } stage_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK_STEP   = 3'd0,
    REG_DECAY_STEP    = 3'd1,
    REG_SUSTAIN_LEVEL = 3'd2,
    REG_RELEASE_STEP  = 3'd3,
    REG_FADE_STEP     = 3'd4
  } cfg_idx_t;

  // reset values of the configuration registers
  localparam logic [LEVEL_W-1:0] RST_ATTACK_STEP   = 24'd350;
  localparam logic [LEVEL_W-1:0] RST_DECAY_STEP    = 24'd350;
  localparam logic [LEVEL_W-1:0] RST_SUSTAIN_LEVEL = 24'd11744051;
  localparam logic [LEVEL_W-1:0] RST_RELEASE_STEP  = 24'd350;
  localparam logic [LEVEL_W-1:0] RST_FADE_STEP     = 24'd3495;

  // current register set, handed from the register file to the update logic
  typedef struct packed {
    logic [LEVEL_W-1:0] attack_step;
    logic [LEVEL_W-1:0] decay_step;
    logic [LEVEL_W-1:0] sustain_level;
    logic [LEVEL_W-1:0] release_step;
    logic [LEVEL_W-1:0] fade_step;
  } cfg_t;

  // level minus step, floored at zero
  function automatic logic [LEVEL_W-1:0] fall_floor(input logic [LEVEL_W-1:0] level,
                                                    input logic [LEVEL_W-1:0] step);
    logic [LEVEL_W-1:0] res;
    if (step >= level) begin
      res = LEVEL_ZERO;
    end else begin
      res = level - step;
    end
    return res;
  endfunction

endpackage

### hw/rtl/ladsr_cfg.sv
// ----------------------------------------------------------------------------
// ladsr_cfg
// Configuration register file: five step/level registers written through a
// plain write port. Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module ladsr_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ladsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ladsr_pkg::LEVEL_W-1:0]       cfg_data,
  output ladsr_pkg::cfg_t                     cfg
);

  ladsr_pkg::cfg_t regs;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.attack_step   <= ladsr_pkg::RST_ATTACK_STEP;
      regs.decay_step    <= ladsr_pkg::RST_DECAY_STEP;
      regs.sustain_level <= ladsr_pkg::RST_SUSTAIN_LEVEL;
      regs.release_step  <= ladsr_pkg::RST_RELEASE_STEP;
      regs.fade_step     <= ladsr_pkg::RST_FADE_STEP;
    end else if (cfg_write) begin
      unique case (ladsr_pkg::cfg_idx_t'(cfg_index))
        ladsr_pkg::REG_ATTACK_STEP:   regs.attack_step   <= cfg_data;
        ladsr_pkg::REG_DECAY_STEP:    regs.decay_step    <= cfg_data;
        ladsr_pkg::REG_SUSTAIN_LEVEL: regs.sustain_level <= cfg_data;
        ladsr_pkg::REG_RELEASE_STEP:  regs.release_step  <= cfg_data;
        ladsr_pkg::REG_FADE_STEP:     regs.fade_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

### hw/rtl/ladsr_update.sv
// ----------------------------------------------------------------------------
// ladsr_update
// One tick of the envelope: stage transition and level step from the current
// stage, level, gate and fade request. Pure logic, one add or subtract and a
// compare on the critical path.
// ----------------------------------------------------------------------------
module ladsr_update (
  input  ladsr_pkg::cfg_t               cfg,
  input  ladsr_pkg::stage_t             stage,
  input  logic [ladsr_pkg::LEVEL_W-1:0] level,
  input  logic                          gate,
  input  logic                          fade,
  output ladsr_pkg::stage_t             stage_next,
  output logic [ladsr_pkg::LEVEL_W-1:0] level_next
);

  ladsr_pkg::stage_t             stage_gated;
  logic [ladsr_pkg::LEVEL_W:0]   attack_sum;
  logic [ladsr_pkg::LEVEL_W-1:0] fade_lvl;
  logic [ladsr_pkg::LEVEL_W-1:0] decay_lvl;
  logic [ladsr_pkg::LEVEL_W-1:0] release_lvl;

  // candidate levels for each ramp
  assign attack_sum  = {1'b0, level} + {1'b0, cfg.attack_step};
  assign fade_lvl    = ladsr_pkg::fall_floor(level, cfg.fade_step);
  assign decay_lvl   = ladsr_pkg::fall_floor(level, cfg.decay_step);
  assign release_lvl = ladsr_pkg::fall_floor(level, cfg.release_step);

  // gate edges: start attack from idle, release from any held stage
  always_comb begin
    stage_gated = stage;
    if (gate && stage == ladsr_pkg::ST_IDLE) begin
      stage_gated = ladsr_pkg::ST_ATTACK;
    end
    if (!gate && stage != ladsr_pkg::ST_IDLE && stage != ladsr_pkg::ST_RELEASE) begin
      stage_gated = ladsr_pkg::ST_RELEASE;
    end
  end

  // per-stage level step; fade request overrides everything
  always_comb begin
    stage_next = stage_gated;
    level_next = level;
    if (fade || stage == ladsr_pkg::ST_FADE) begin
      level_next = fade_lvl;
      stage_next = (fade_lvl == ladsr_pkg::LEVEL_ZERO) ? ladsr_pkg::ST_IDLE
                                                       : ladsr_pkg::ST_FADE;
    end else begin
      unique case (stage_gated)
        ladsr_pkg::ST_ATTACK: begin
          if (attack_sum >= {1'b0, ladsr_pkg::LEVEL_FULL}) begin
            level_next = ladsr_pkg::LEVEL_FULL;
            stage_next = ladsr_pkg::ST_DECAY;
          end else begin
            level_next = attack_sum[ladsr_pkg::LEVEL_W-1:0];
          end
        end
        ladsr_pkg::ST_DECAY: begin
          if (decay_lvl <= cfg.sustain_level) begin
            level_next = cfg.sustain_level;
            stage_next = ladsr_pkg::ST_SUSTAIN;
          end else begin
            level_next = decay_lvl;
          end
        end
        ladsr_pkg::ST_SUSTAIN: begin
          level_next = cfg.sustain_level;
        end
        ladsr_pkg::ST_RELEASE: begin
          level_next = release_lvl;
          if (release_lvl == ladsr_pkg::LEVEL_ZERO) begin
            stage_next = ladsr_pkg::ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/linear_adsr_envelope.sv
// ----------------------------------------------------------------------------
// linear_adsr_envelope
// Linear ADSR envelope with forced fade-out. One input word is one sample
// tick; one result word with the new level and stage comes out per tick.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid/in_stall   note_gate, fade_request
//   out      from block out_valid/out_stall envelope_level, stage_code
//   cfg      to block   cfg_write           cfg_index, cfg_data
//
// One word per cycle sustained while out_stall stays low; an accepted input
// word is held in the input register, then moves into the state/result
// register once the result slot is free or its word is being taken.
// The level/stage registers are both the envelope state and the result word,
// so one add/subtract and compare sits between the two register ranks.
// Reset clears the stage to idle, the level to zero and loads the register
// defaults. A stalled result holds; the input register still takes one word
// while the result waits.
// ----------------------------------------------------------------------------
module linear_adsr_envelope (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                note_gate,
  input  logic                                fade_request,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ladsr_pkg::LEVEL_W-1:0]       envelope_level,
  output logic [ladsr_pkg::STAGE_W-1:0]       stage_code,
  input  logic                                cfg_write,
  input  logic [ladsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ladsr_pkg::LEVEL_W-1:0]       cfg_data
);

  ladsr_pkg::cfg_t               cfg;
  logic                          in_full;
  logic                          gate_q;
  logic                          fade_q;
  logic                          advance;
  ladsr_pkg::stage_t             stage_reg;
  logic [ladsr_pkg::LEVEL_W-1:0] level_reg;
  ladsr_pkg::stage_t             stage_next;
  logic [ladsr_pkg::LEVEL_W-1:0] level_next;

  ladsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ladsr_update u_update (
    .cfg        (cfg),
    .stage      (stage_reg),
    .level      (level_reg),
    .gate       (gate_q),
    .fade       (fade_q),
    .stage_next (stage_next),
    .level_next (level_next)
  );

  // the held word moves on when the result slot is free or being taken
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      gate_q <= note_gate;
      fade_q <= fade_request;
    end
  end

  // envelope state, doubling as the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      stage_reg <= ladsr_pkg::ST_IDLE;
      level_reg <= ladsr_pkg::LEVEL_ZERO;
    end else if (advance) begin
      out_valid <= 1'b1;
      stage_reg <= stage_next;
      level_reg <= level_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign envelope_level = level_reg;
  assign stage_code     = stage_reg;

endmodule

### hw/rtl/ladsr_checker.sv
// ----------------------------------------------------------------------------
// ladsr_checker
// Port-level checks on the envelope result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ladsr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ladsr_pkg::LEVEL_W-1:0] envelope_level,
  input logic [ladsr_pkg::STAGE_W-1:0] stage_code
);

  // a stalled result word stays put
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(envelope_level) && $stable(stage_code), "stalled result word changed")

  // idle is only ever reported at zero level
  `CHK_SAME(a_idle_zero, out_valid && stage_code == ladsr_pkg::ST_IDLE, envelope_level == ladsr_pkg::LEVEL_ZERO, "idle with nonzero level")

  // attack hands over to decay on reaching full scale
  `CHK_SAME(a_attack_below_full, out_valid && stage_code == ladsr_pkg::ST_ATTACK, envelope_level != ladsr_pkg::LEVEL_FULL, "attack reported at full scale")

  // decay stays above sustain, so never at zero
  `CHK_SAME(a_decay_nonzero, out_valid && stage_code == ladsr_pkg::ST_DECAY, envelope_level != ladsr_pkg::LEVEL_ZERO, "decay reported at zero level")

endmodule

bind linear_adsr_envelope ladsr_checker u_ladsr_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .envelope_level (envelope_level),
  .stage_code     (stage_code)
);

### tb/sv/linear_adsr_envelope_tb.sv
// ----------------------------------------------------------------------------
// linear_adsr_envelope_tb
// Self-checking bench for the linear ADSR envelope. Tick words go in with
// random sender gaps. Result words come back under random receiver stalls.
// Each result is compared against an in-bench envelope tracker. A directed
// part covers defaults, extremes, retrigger in release, the sustain jump and
// zero steps. Random note sequences then run under several idle/stall mixes.
// ----------------------------------------------------------------------------
module linear_adsr_envelope_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_TAIL  = 4;
  // first index past the register file; writes there must be dropped
  localparam logic [ladsr_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;

  typedef struct packed {
    logic [ladsr_pkg::LEVEL_W-1:0] level;
    ladsr_pkg::stage_t             stage;
  } env_word_t;

  // dut ports
  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            note_gate = 1'b0;
  logic                            fade_request = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [ladsr_pkg::LEVEL_W-1:0]   envelope_level;
  logic [ladsr_pkg::STAGE_W-1:0]   stage_code;
  logic                            cfg_write = 1'b0;
  logic [ladsr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ladsr_pkg::LEVEL_W-1:0]   cfg_data = '0;

  // shadow register set and envelope state
  logic [ladsr_pkg::LEVEL_W-1:0] atk_step_q = ladsr_pkg::RST_ATTACK_STEP;
  logic [ladsr_pkg::LEVEL_W-1:0] dec_step_q = ladsr_pkg::RST_DECAY_STEP;
  logic [ladsr_pkg::LEVEL_W-1:0] sus_level_q = ladsr_pkg::RST_SUSTAIN_LEVEL;
  logic [ladsr_pkg::LEVEL_W-1:0] rel_step_q = ladsr_pkg::RST_RELEASE_STEP;
  logic [ladsr_pkg::LEVEL_W-1:0] fade_step_q = ladsr_pkg::RST_FADE_STEP;
  ladsr_pkg::stage_t             env_stage = ladsr_pkg::ST_IDLE;
  logic [ladsr_pkg::LEVEL_W-1:0] env_level = ladsr_pkg::LEVEL_ZERO;

  env_word_t pending_env[$];
  int        mismatches = 0;
  int        ticks_sent = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  linear_adsr_envelope uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .note_gate      (note_gate),
    .fade_request   (fade_request),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .envelope_level (envelope_level),
    .stage_code     (stage_code),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // level minus step, floored at zero
  function automatic logic [ladsr_pkg::LEVEL_W-1:0] floored_drop(
      input logic [ladsr_pkg::LEVEL_W-1:0] lvl,
      input logic [ladsr_pkg::LEVEL_W-1:0] step);
    if (step >= lvl) begin
      return ladsr_pkg::LEVEL_ZERO;
    end
    return lvl - step;
  endfunction

  // one sample tick of the envelope; updates the tracked state
  function automatic env_word_t advance_envelope(input logic gate, input logic fade);
    logic [ladsr_pkg::LEVEL_W:0] sum;
    env_word_t                   res;
    if (fade) begin
      env_stage = ladsr_pkg::ST_FADE;
    end
    if (env_stage == ladsr_pkg::ST_FADE) begin
      env_level = floored_drop(env_level, fade_step_q);
      if (env_level == ladsr_pkg::LEVEL_ZERO) begin
        env_stage = ladsr_pkg::ST_IDLE;
      end
    end else begin
      if (gate && env_stage == ladsr_pkg::ST_IDLE) begin
        env_stage = ladsr_pkg::ST_ATTACK;
      end
      if (!gate && env_stage != ladsr_pkg::ST_IDLE && env_stage != ladsr_pkg::ST_RELEASE) begin
        env_stage = ladsr_pkg::ST_RELEASE;
      end
      case (env_stage)
        ladsr_pkg::ST_ATTACK: begin
          sum = {1'b0, env_level} + {1'b0, atk_step_q};
          if (sum >= {1'b0, ladsr_pkg::LEVEL_FULL}) begin
            env_level = ladsr_pkg::LEVEL_FULL;
            env_stage = ladsr_pkg::ST_DECAY;
          end else begin
            env_level = sum[ladsr_pkg::LEVEL_W-1:0];
          end
        end
        ladsr_pkg::ST_DECAY: begin
          env_level = floored_drop(env_level, dec_step_q);
          // may jump up when sustain sits above the decremented level
          if (env_level <= sus_level_q) begin
            env_level = sus_level_q;
            env_stage = ladsr_pkg::ST_SUSTAIN;
          end
        end
        ladsr_pkg::ST_SUSTAIN: begin
          env_level = sus_level_q;
        end
        ladsr_pkg::ST_RELEASE: begin
          env_level = floored_drop(env_level, rel_step_q);
          if (env_level == ladsr_pkg::LEVEL_ZERO) begin
            env_stage = ladsr_pkg::ST_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
    res.level = env_level;
    res.stage = env_stage;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  // negedge sampling: nothing driven by the bench moves between here and the
  // next rising edge, so these are the values that edge will see
  always @(negedge clk) begin
    env_word_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_env.push_back(advance_envelope(note_gate, fade_request));
      end
      if (out_valid && !out_stall) begin
        if (pending_env.size() == 0) begin
          report_mismatch("unexpected result word", 32'(envelope_level), 32'd0);
        end else begin
          want = pending_env.pop_front();
          if (envelope_level !== want.level) begin
            report_mismatch("envelope_level", 32'(envelope_level), 32'(want.level));
          end
          if (stage_code !== want.stage) begin
            report_mismatch("stage_code", 32'(stage_code), 32'(want.stage));
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // send one tick word; called and returns at a rising edge
  task automatic send_tick(input logic gate, input logic fade);
    logic stall_seen;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      note_gate <= 1'($urandom_range(0, 1));
      fade_request <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    note_gate <= gate;
    fade_request <= fade;
    stall_seen = 1'b1;
    while (stall_seen) begin
      @(negedge clk);
      stall_seen = in_stall;
      @(posedge clk);
    end
    ticks_sent++;
  endtask

  // hold the sender until every result word is back, then let the pipe settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_env.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // one register write; caller lowers cfg_write after its last write
  task automatic write_reg(input logic [ladsr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ladsr_pkg::LEVEL_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      ladsr_pkg::REG_ATTACK_STEP:   atk_step_q = val;
      ladsr_pkg::REG_DECAY_STEP:    dec_step_q = val;
      ladsr_pkg::REG_SUSTAIN_LEVEL: sus_level_q = val;
      ladsr_pkg::REG_RELEASE_STEP:  rel_step_q = val;
      ladsr_pkg::REG_FADE_STEP:     fade_step_q = val;
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [ladsr_pkg::LEVEL_W-1:0] atk,
                            input logic [ladsr_pkg::LEVEL_W-1:0] dec,
                            input logic [ladsr_pkg::LEVEL_W-1:0] sus,
                            input logic [ladsr_pkg::LEVEL_W-1:0] rel,
                            input logic [ladsr_pkg::LEVEL_W-1:0] fad);
    wait_drain();
    write_reg(ladsr_pkg::REG_ATTACK_STEP, atk);
    write_reg(ladsr_pkg::REG_DECAY_STEP, dec);
    write_reg(ladsr_pkg::REG_SUSTAIN_LEVEL, sus);
    write_reg(ladsr_pkg::REG_RELEASE_STEP, rel);
    write_reg(ladsr_pkg::REG_FADE_STEP, fad);
    cfg_write <= 1'b0;
  endtask

  // reset defaults: slow attack, release, retrigger in release, fades
  task automatic test_defaults();
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    // gate back high in release must not retrigger
    send_tick(1'b1, 1'b0);
    // fade request in idle at zero
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  // full-scale steps, sustain jump, sustain at full scale
  task automatic test_extremes();
    set_config(ladsr_pkg::LEVEL_FULL, ladsr_pkg::LEVEL_FULL, 24'h123456,
               ladsr_pkg::LEVEL_FULL, ladsr_pkg::LEVEL_FULL);
    send_tick(1'b1, 1'b0);
    // decay floors at zero, then jumps up to sustain
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    set_config(ladsr_pkg::LEVEL_FULL, 24'd1, ladsr_pkg::LEVEL_FULL, 24'd1, 24'd1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
  endtask

  // zero steps and writes past the register file
  task automatic test_zero_steps();
    set_config(ladsr_pkg::LEVEL_ZERO, ladsr_pkg::LEVEL_ZERO, ladsr_pkg::LEVEL_ZERO,
               ladsr_pkg::LEVEL_ZERO, ladsr_pkg::LEVEL_ZERO);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    wait_drain();
    write_reg(ladsr_pkg::REG_ATTACK_STEP, 24'd1);
    for (int i = REG_SPARE_FIRST; i < (1 << ladsr_pkg::CFG_IDX_W); i++) begin
      write_reg(i[ladsr_pkg::CFG_IDX_W-1:0], ladsr_pkg::LEVEL_W'($urandom()));
    end
    cfg_write <= 1'b0;
    send_tick(1'b1, 1'b0);
    // zero release step holds the level in release
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
  endtask

  function automatic logic [ladsr_pkg::LEVEL_W-1:0] pick_step();
    case ($urandom_range(0, 15))
      0:       return ladsr_pkg::LEVEL_W'($urandom());
      1:       return ladsr_pkg::LEVEL_FULL;
      2:       return 24'd1;
      3:       return ladsr_pkg::LEVEL_ZERO;
      default: return ladsr_pkg::LEVEL_W'(ladsr_pkg::LEVEL_FULL / $urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [ladsr_pkg::LEVEL_W-1:0] pick_sustain();
    case ($urandom_range(0, 7))
      0:       return ladsr_pkg::LEVEL_ZERO;
      1:       return ladsr_pkg::LEVEL_FULL;
      default: return ladsr_pkg::LEVEL_W'($urandom());
    endcase
  endfunction

  // press, hold, release; now and then a fade request lands inside
  task automatic play_note();
    int hold;
    int tail;
    int fade_at;
    hold = $urandom_range(1, 32);
    tail = $urandom_range(1, 24);
    fade_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, hold + tail - 1) : -1;
    for (int i = 0; i < hold + tail; i++) begin
      send_tick(i < hold, i == fade_at);
    end
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
    int start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = ticks_sent;
    while (ticks_sent - start < n) begin
      if ($urandom_range(0, 3) == 0) begin
        set_config(pick_step(), pick_step(), pick_sustain(), pick_step(), pick_step());
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
        end
      end else begin
        play_note();
      end
      if ($urandom_range(0, 15) == 0) begin
        wait_drain();
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_extremes();
    test_zero_steps();
    test_random_phase(0, 0, 220);
    test_random_phase(59, 0, 220);
    test_random_phase(0, 59, 220);
    test_random_phase(19, 19, 220);
    wait_drain();
    recv_stall_pct = 0;
    repeat (DRAIN_TAIL) @(posedge clk);
    if (pending_env.size() != 0) begin
      report_mismatch("result words missing", pending_env.size(), 32'd0);
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
